@@ rtl/acdt_pkg.sv @@
// Shared types, constants and helpers for the audio clock drift tracker.
// Used by the multiplier, the divider and the top level of the block; depends on nothing.
`timescale 1ns / 1ps

package acdt_pkg;

	localparam int unsigned DATA_W    = 64;
	localparam int unsigned UPF_W     = 32;
	localparam int unsigned DRIFT_W   = 32;
	localparam int unsigned PROD_W    = DATA_W + UPF_W;
	localparam int unsigned CFG_IDX_W = 4;

	// right shifts applied to the 96-bit products
	localparam int unsigned EST_SHIFT   = 30;
	localparam int unsigned FRAME_SHIFT = 24;

	// quotient bits of the slope: two integer, thirty fraction
	localparam int unsigned QUOT_BITS = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_USECS_PER_FRAME = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_BASE_TIME  = 4'd1;

	localparam logic [UPF_W-1:0]   UPF_RESET = 32'h0100_0000;
	localparam logic [DRIFT_W-1:0] DRIFT_ONE = 32'h4000_0000;
	localparam logic [DRIFT_W-1:0] DRIFT_SAT = 32'hFFFF_FFFF;

	// shared multiplier request/response
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [UPF_W-1:0]  b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] product;
	} mul_rsp_t;

	// serial divider request/response
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_BITS-1:0] quot;
	} div_rsp_t;

	// magnitude of a two's complement word; the most negative value maps to 2^63
	function automatic logic [DATA_W-1:0] mag64(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

@@ rtl/acdt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the timestamp history; no dependencies.
`timescale 1ns / 1ps

module acdt_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/acdt_mul.sv @@
// Shared 64x32 multiplier built from one 32x32 multiplier over two passes.
// Depends on acdt_pkg for the request/response structs.
`timescale 1ns / 1ps

module acdt_mul
	import acdt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_LO,
		M_HI,
		M_SUM
	} mstate_t;

	localparam int unsigned HALF_W = DATA_W / 2;

	mstate_t              state_q;
	logic                 done_q;
	logic [DATA_W-1:0]    a_q;
	logic [UPF_W-1:0]     b_q;
	logic [HALF_W+UPF_W-1:0] p_q;
	logic [PROD_W-1:0]    acc_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_LO;
					end
				end
				M_LO:    state_q <= M_HI;
				M_HI:    state_q <= M_SUM;
				M_SUM: begin
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// low half product, then high half product shifted in
	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (req.start) begin
					a_q <= req.a;
					b_q <= req.b;
				end
			end
			M_LO: p_q <= a_q[HALF_W-1:0] * b_q;
			M_HI: begin
				acc_q <= {{(PROD_W-HALF_W-UPF_W){1'b0}}, p_q};
				p_q   <= a_q[DATA_W-1:HALF_W] * b_q;
			end
			M_SUM: acc_q <= acc_q + {p_q, {HALF_W{1'b0}}};
			default: ;
		endcase
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

@@ rtl/acdt_div.sv @@
// Restoring divider producing the Q2.30 slope, one quotient bit per cycle.
// Expects num < 4*den and den nonzero; depends on acdt_pkg.
`timescale 1ns / 1ps

module acdt_div
	import acdt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	typedef enum logic {
		D_IDLE,
		D_RUN
	} dstate_t;

	localparam int unsigned CNT_W = $clog2(QUOT_BITS);

	dstate_t              state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [DATA_W-1:0]    r_q;
	logic [DATA_W-1:0]    d_q;
	logic [1:0]           nb_q;
	logic [QUOT_BITS-1:0] quot_q;

	logic [DATA_W:0] trial;
	logic [DATA_W:0] diff;
	logic            ge;

	// shift in the next dividend bit (two integer bits, then zeros)
	assign trial = {r_q, nb_q[1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUOT_BITS - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			r_q    <= {2'b00, req.num[DATA_W-1:2]};
			nb_q   <= req.num[1:0];
			d_q    <= req.den;
			quot_q <= '0;
		end else if (state_q == D_RUN) begin
			r_q    <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			nb_q   <= {nb_q[0], 1'b0};
			quot_q <= {quot_q[QUOT_BITS-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ rtl/audio_clock_drift_tracker_top.sv @@
// Top level of the audio clock drift tracker: sequencer, state and history.
// Uses acdt_pkg, acdt_ram, acdt_mul and acdt_div.
//
// Usage:
// A request on the input channel (in_valid/in_ready) carries one timestamp:
// real_time in microseconds and the frame_count reached at that time. Each
// request gives exactly one result on the output channel (out_valid/out_ready):
// performance_time, drift (Q2.30) and rebased.
// The block works on one request at a time; in_ready is high only while the
// sequencer is idle. A rebasing request makes one pass through the shared
// multiplier; any other makes two passes and then runs the 32-step serial
// divider for the slope, unless the slope is zero, saturated or kept and no
// divide runs. in_ready returns in the cycle after the result is loaded.
// Results sit in an output register, so the next request is accepted while a
// result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds it until the register frees.
// Reset (arst_n low) restores the register defaults, sets drift to 1.0 and
// makes the next request rebase. Registers are written through cfg_we,
// cfg_index and cfg_data while the block is idle; either write makes the next
// request rebase and empties the history.
`timescale 1ns / 1ps

module audio_clock_drift_tracker_top
	import acdt_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [63:0]   real_time,
	input  logic [63:0]          frame_count,
	// output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [63:0]   performance_time,
	output logic [31:0]          drift,
	output logic                 rebased,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIFF,
		S_EST_MUL,
		S_EST_WAIT,
		S_EST_ADD,
		S_REBASE,
		S_FR_DIFF,
		S_FR_MUL,
		S_FR_WAIT,
		S_AVG_SUM,
		S_AVG,
		S_DELTA,
		S_MAG,
		S_CHECK,
		S_DIV,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	// architectural state
	state_t             state_q;
	logic [UPF_W-1:0]   upf_q;
	logic [DATA_W-1:0]  last_real_q;
	logic [DATA_W-1:0]  perf_now_q;
	logic [DRIFT_W-1:0] drift_q;
	logic [DATA_W-1:0]  perf_base_q;
	logic [DATA_W-1:0]  frame_base_q;
	logic               rebase_pending_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [IDX_W-1:0]   newest_q;
	logic               out_valid_q;

	// working registers
	logic [DATA_W-1:0]  rt_q;
	logic [DATA_W-1:0]  fr_q;
	logic               rb_q;
	logic [DATA_W-1:0]  a_q;
	logic               neg_q;
	logic [DATA_W-1:0]  sc_q;
	logic [DATA_W-1:0]  est_q;
	logic [DATA_W-1:0]  pt_q;
	logic [DATA_W:0]    sum_q;
	logic [DATA_W-1:0]  num_q;
	logic [DATA_W-1:0]  den_q;
	logic [DATA_W-1:0]  n_q;
	logic [DATA_W-1:0]  d_q;
	logic               sgn_q;
	logic [IDX_W-1:0]   rd_addr_q;
	logic [DATA_W-1:0]  out_perf_q;
	logic [DRIFT_W-1:0] out_drift_q;
	logic               out_rebased_q;

	logic [IDX_W-1:0]    newest_nx;
	logic [IDX_W-1:0]    oldest_nx;
	logic [DATA_W-1:0]   real_diff;
	logic [DATA_W:0]     avg_full;
	logic [2*DATA_W-1:0] ram_wdata;
	logic [2*DATA_W-1:0] ram_rdata;
	logic                ram_we;
	logic                out_load;
	mul_req_t            mul_req;
	mul_rsp_t            mul_rsp;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// ring pointers after adding one entry
	assign newest_nx = wrap_inc(newest_q);
	assign oldest_nx = (newest_nx == oldest_q) ? wrap_inc(oldest_q) : oldest_q;

	assign real_diff = rt_q - last_real_q;
	// round the halved sum toward zero
	assign avg_full  = sum_q + {{DATA_W{1'b0}}, sum_q[DATA_W]};
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// history ring: {real time, performance time}
	assign ram_we    = (state_q == S_REBASE) || (state_q == S_AVG_SUM);
	assign ram_wdata = {rt_q, (state_q == S_REBASE) ? est_q : pt_q};

	acdt_ram #(
		.WIDTH(2 * DATA_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(newest_nx),
		.wdata(ram_wdata),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// shared multiplier: drift scaling, then frame conversion
	assign mul_req.start = (state_q == S_EST_MUL) || (state_q == S_FR_MUL);
	assign mul_req.a     = a_q;
	assign mul_req.b     = (state_q == S_FR_MUL) ? upf_q : drift_q;

	acdt_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req),
		.rsp   (mul_rsp)
	);

	assign div_req.start = (state_q == S_DIV);
	assign div_req.num   = n_q;
	assign div_req.den   = d_q;

	acdt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			upf_q            <= UPF_RESET;
			last_real_q      <= '0;
			perf_now_q       <= '0;
			drift_q          <= DRIFT_ONE;
			perf_base_q      <= '0;
			frame_base_q     <= '0;
			rebase_pending_q <= 1'b1;
			oldest_q         <= '0;
			newest_q         <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			// output register: set on load, cleared when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_USECS_PER_FRAME: begin
						upf_q            <= cfg_data[UPF_W-1:0];
						rebase_pending_q <= 1'b1;
						oldest_q         <= '0;
						newest_q         <= '0;
					end
					REG_REAL_BASE_TIME: begin
						last_real_q      <= cfg_data;
						perf_now_q       <= '0;
						drift_q          <= DRIFT_ONE;
						rebase_pending_q <= 1'b1;
						oldest_q         <= '0;
						newest_q         <= '0;
					end
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF:    state_q <= S_EST_MUL;
				S_EST_MUL: state_q <= S_EST_WAIT;
				S_EST_WAIT: begin
					if (mul_rsp.done) begin
						state_q <= S_EST_ADD;
					end
				end
				S_EST_ADD: state_q <= rb_q ? S_REBASE : S_FR_DIFF;
				S_REBASE: begin
					perf_now_q       <= est_q;
					perf_base_q      <= est_q;
					frame_base_q     <= fr_q;
					rebase_pending_q <= 1'b0;
					last_real_q      <= rt_q;
					newest_q         <= newest_nx;
					oldest_q         <= newest_nx;
					state_q          <= S_DONE;
				end
				S_FR_DIFF: state_q <= S_FR_MUL;
				S_FR_MUL:  state_q <= S_FR_WAIT;
				S_FR_WAIT: begin
					if (mul_rsp.done) begin
						state_q <= S_AVG_SUM;
					end
				end
				S_AVG_SUM: begin
					last_real_q <= rt_q;
					newest_q    <= newest_nx;
					oldest_q    <= oldest_nx;
					state_q     <= S_AVG;
				end
				S_AVG: begin
					perf_now_q <= avg_full[DATA_W:1];
					state_q    <= S_DELTA;
				end
				S_DELTA: state_q <= S_MAG;
				S_MAG:   state_q <= S_CHECK;
				S_CHECK: begin
					// zero time span keeps the old drift
					if (d_q == '0) begin
						state_q <= S_DONE;
					end else if (n_q == '0 || sgn_q) begin
						drift_q <= '0;
						state_q <= S_DONE;
					end else if ((n_q >> 2) >= d_q) begin
						drift_q <= DRIFT_SAT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						drift_q <= div_rsp.quot;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					rt_q <= real_time;
					fr_q <= frame_count;
					rb_q <= rebase_pending_q;
				end
			end
			S_DIFF: begin
				a_q       <= mag64(real_diff);
				neg_q     <= real_diff[DATA_W-1];
				rd_addr_q <= oldest_nx;
			end
			S_EST_WAIT: begin
				if (mul_rsp.done) begin
					sc_q <= mul_rsp.product[EST_SHIFT+DATA_W-1:EST_SHIFT];
				end
			end
			S_EST_ADD: est_q <= neg_q ? (perf_now_q - sc_q) : (perf_now_q + sc_q);
			S_FR_DIFF: a_q <= fr_q - frame_base_q;
			S_FR_WAIT: begin
				if (mul_rsp.done) begin
					pt_q <= perf_base_q
						+ mul_rsp.product[FRAME_SHIFT+DATA_W-1:FRAME_SHIFT];
				end
			end
			S_AVG_SUM: sum_q <= {pt_q[DATA_W-1], pt_q} + {est_q[DATA_W-1], est_q};
			S_DELTA: begin
				num_q <= perf_now_q - ram_rdata[DATA_W-1:0];
				den_q <= rt_q - ram_rdata[2*DATA_W-1:DATA_W];
			end
			S_MAG: begin
				n_q   <= mag64(num_q);
				d_q   <= mag64(den_q);
				sgn_q <= num_q[DATA_W-1] ^ den_q[DATA_W-1];
			end
			S_DONE: begin
				if (out_load) begin
					out_perf_q    <= perf_now_q;
					out_drift_q   <= drift_q;
					out_rebased_q <= rb_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign performance_time = out_perf_q;
	assign drift            = out_drift_q;
	assign rebased          = out_rebased_q;

`ifndef NO_ASSERTIONS
	// one request at a time: ready drops right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input accepted while a request is in flight");

	// divider only sees operands with a quotient below four
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> (n_q != '0) && (d_q != '0) && ((n_q >> 2) < d_q))
	else $error("divider started outside its range");

	// multiplier results arrive only while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_EST_WAIT) || (state_q == S_FR_WAIT))
	else $error("unexpected multiplier result");

	// a result, once loaded, is shown as valid at the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
	else $error("result lost at output register");
`endif

endmodule

@@ tb/audio_clock_drift_tracker_checker.sv @@
// Result checker for the audio clock drift tracker: mirrors the registers and the
// tracking state, predicts each result and compares it with what the block returns.
// Depends on acdt_pkg for widths, register indexes and drift constants.
`timescale 1ns / 1ps

module audio_clock_drift_tracker_checker
	import acdt_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [63:0]   real_time,
	input  logic [63:0]          frame_count,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [63:0]   performance_time,
	input  logic [31:0]          drift,
	input  logic                 rebased,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output int                   fail_count,
	output int                   results_pending
);

	typedef struct {
		logic [63:0] perf_time;
		logic [31:0] drift_q30;
		logic        rebased;
	} stamp_result_t;

	stamp_result_t awaited_results[$];
	stamp_result_t oldest_want;

	// register mirror
	logic [UPF_W-1:0] upf_q24;

	// tracking state
	logic [63:0]  prev_real;
	logic [63:0]  perf_est;
	logic [63:0]  perf_origin;
	logic [63:0]  frame_origin;
	logic [31:0]  drift_now;
	logic         rebase_next;
	int unsigned  head_idx;
	int unsigned  tail_idx;
	logic [63:0]  ring_real [HISTORY_DEPTH];
	logic [63:0]  ring_perf [HISTORY_DEPTH];
	int           errors;

	function automatic logic [63:0] abs_word(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// low 64 bits of the exact 96-bit product shifted right
	function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [31:0] b,
			input int unsigned sh);
		logic [95:0] p;
		p = {32'd0, a} * {64'd0, b};
		p = p >> sh;
		return p[63:0];
	endfunction

	// signed time difference times Q2.30 drift, toward zero
	function automatic logic [63:0] drift_scaled(input logic [63:0] dt, input logic [31:0] d);
		logic [63:0] m;
		m = scaled_product(abs_word(dt), d, EST_SHIFT);
		return dt[63] ? (64'd0 - m) : m;
	endfunction

	// average of two signed words, exact sum, truncated toward zero
	function automatic logic [63:0] midpoint(input logic [63:0] a, input logic [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s[64] && s[0])
			s = s + 65'sd1;
		s = s >>> 1;
		return s[63:0];
	endfunction

	// Q2.30 ratio, zero when negative, saturated at four
	function automatic logic [31:0] slope_q30(input logic [63:0] num, input logic [63:0] den);
		logic [93:0] q;
		if (num == 64'd0)
			return 32'd0;
		if (num[63] != den[63])
			return 32'd0;
		q = {abs_word(num), 30'd0} / {30'd0, abs_word(den)};
		if (q[93:32] != '0)
			return DRIFT_SAT;
		return q[31:0];
	endfunction

	function automatic void restart_history();
		rebase_next = 1'b1;
		head_idx    = 0;
		tail_idx    = 0;
	endfunction

	function automatic void push_history(input logic [63:0] rt, input logic [63:0] pt);
		tail_idx = (tail_idx + 1) % HISTORY_DEPTH;
		ring_real[tail_idx] = rt;
		ring_perf[tail_idx] = pt;
		if (tail_idx == head_idx)
			head_idx = (head_idx + 1) % HISTORY_DEPTH;
	endfunction

	// advance the tracker by one timestamp and return the expected result
	function automatic stamp_result_t track_stamp(input logic [63:0] rt, input logic [63:0] fc);
		stamp_result_t res;
		logic [63:0]   est;
		logic [63:0]   fresh;
		logic [63:0]   span;
		est = perf_est + drift_scaled(rt - prev_real, drift_now);
		prev_real = rt;
		if (rebase_next) begin
			perf_est     = est;
			perf_origin  = est;
			frame_origin = fc;
			rebase_next  = 1'b0;
			push_history(rt, est);
			head_idx     = tail_idx;
			res.rebased  = 1'b1;
		end else begin
			fresh = perf_origin + scaled_product(fc - frame_origin, upf_q24, FRAME_SHIFT);
			push_history(rt, fresh);
			perf_est = midpoint(fresh, est);
			span = rt - ring_real[head_idx];
			// equal times against the oldest entry keep the old drift
			if (span != 64'd0)
				drift_now = slope_q30(perf_est - ring_perf[head_idx], span);
			res.rebased = 1'b0;
		end
		res.perf_time = perf_est;
		res.drift_q30 = drift_now;
		return res;
	endfunction

	// watch config writes, accepted requests and accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upf_q24      = UPF_RESET;
			prev_real    = 64'd0;
			perf_est     = 64'd0;
			perf_origin  = 64'd0;
			frame_origin = 64'd0;
			drift_now    = DRIFT_ONE;
			restart_history();
			awaited_results.delete();
			errors = 0;
			fail_count      <= 0;
			results_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_USECS_PER_FRAME: begin
						upf_q24 = cfg_data[UPF_W-1:0];
						restart_history();
					end
					REG_REAL_BASE_TIME: begin
						prev_real = cfg_data;
						perf_est  = 64'd0;
						drift_now = DRIFT_ONE;
						restart_history();
					end
					default: begin
					end
				endcase
			end

			if (in_valid && in_ready)
				awaited_results.push_back(track_stamp(real_time, frame_count));

			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$error("result with nothing awaited: performance_time %0d", performance_time);
				end else begin
					oldest_want = awaited_results.pop_front();
					if (performance_time !== oldest_want.perf_time) begin
						errors++;
						$error("performance_time: expected %0d, got %0d",
							$signed(oldest_want.perf_time), performance_time);
					end
					if (drift !== oldest_want.drift_q30) begin
						errors++;
						$error("drift: expected %08h, got %08h", oldest_want.drift_q30, drift);
					end
					if (rebased !== oldest_want.rebased) begin
						errors++;
						$error("rebased: expected %0b, got %0b", oldest_want.rebased, rebased);
					end
				end
			end

			fail_count      <= errors;
			results_pending <= awaited_results.size();
		end
	end

endmodule

@@ tb/audio_clock_drift_tracker_top_test.sv @@
// Testbench top for the audio clock drift tracker: clock, reset, timestamp stimulus,
// receiver stalls and the verdict. Checking is done by audio_clock_drift_tracker_checker.
// Depends on acdt_pkg and audio_clock_drift_tracker_top.
`timescale 1ns / 1ps

module audio_clock_drift_tracker_top_test;
	import acdt_pkg::*;

	localparam int unsigned DEPTH = 32;

	localparam logic [63:0] TIME_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] UPF_48K  = 32'd349525333;
	localparam logic [31:0] UPF_MAX  = 32'hFFFF_FFFF;

	// indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic signed [63:0]   real_time   = '0;
	logic [63:0]          frame_count = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic signed [63:0]   performance_time;
	logic [31:0]          drift;
	logic                 rebased;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [63:0]          cfg_data    = '0;

	int fail_count;
	int results_pending;

	// stimulus controls read by the receiver and by send_stamp
	bit calm      = 1'b0;
	bit long_hold = 1'b0;
	bit gaps_on   = 1'b1;

	logic [31:0] rate_q24 = UPF_RESET;

	audio_clock_drift_tracker_top #(
		.HISTORY_DEPTH(DEPTH)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.real_time        (real_time),
		.frame_count      (frame_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.performance_time (performance_time),
		.drift            (drift),
		.rebased          (rebased),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	audio_clock_drift_tracker_checker #(
		.HISTORY_DEPTH(DEPTH)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.real_time        (real_time),
		.frame_count      (frame_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.performance_time (performance_time),
		.drift            (drift),
		.rebased          (rebased),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.results_pending  (results_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random ready stretches and stalls, one long hold-off on request
	initial begin
		repeat (3) @(posedge clk);
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if (long_hold) begin
				long_hold = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if ($urandom_range(3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// offer one timestamp request and hold it until accepted; valid stays high after
	task automatic send_stamp(input logic [63:0] rt, input logic [63:0] fc);
		if (gaps_on && !calm && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		real_time   <= rt;
		frame_count <= fc;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// wait until every result is back and the block is idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write enable is left high; the caller lowers it after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_USECS_PER_FRAME)
			rate_q24 = val[31:0];
		@(posedge clk);
	endtask

	// mostly steady timestamps with clock jitter, some broken steps and noise
	task automatic run_random_phase(input int count);
		logic [63:0] now_rt;
		logic [63:0] now_fc;
		logic [63:0] step;
		logic [63:0] nominal;
		logic [63:0] spread;
		int          roll;
		now_rt = rand64();
		now_fc = rand64();
		send_stamp(now_rt, now_fc);
		// same time as the base entry
		if ($urandom_range(2) == 0)
			send_stamp(now_rt, now_fc + 64'($urandom_range(0, 50)));
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 75) begin
				step    = 64'($urandom_range(1, 20000));
				nominal = (step << 24) / {32'd0, rate_q24};
				spread  = nominal >> 7;
				if (spread > 64'h3FFF_FFFF)
					spread = 64'h3FFF_FFFF;
				spread  = spread + 64'd1;
				now_rt  = now_rt + step;
				now_fc  = now_fc + nominal + 64'($urandom_range(0, 32'(2 * spread))) - spread;
			end else if (roll < 88) begin
				case ($urandom_range(2))
					0: now_rt = now_rt - 64'($urandom_range(1, 100000));
					1: now_fc = now_fc + (rand64() >> $urandom_range(0, 63));
					default: now_fc = now_fc - 64'($urandom_range(1, 5000));
				endcase
			end else if (roll < 95) begin
				now_rt = rand64();
				now_fc = rand64();
			end else begin
				case ($urandom_range(3))
					0: now_rt = TIME_MIN;
					1: now_rt = TIME_MAX;
					2: now_rt = 64'd0;
					default: now_rt = ALL_ONES;
				endcase
				now_fc = $urandom_range(1) ? ALL_ONES : 64'd0;
			end
			send_stamp(now_rt, now_fc);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default registers, rebase from reset
		send_stamp(64'd1000, 64'd0);
		send_stamp(64'd1000, 64'd7);
		send_stamp(64'd2000, 64'd1000);
		send_stamp(64'd3000, 64'd2000);
		send_stamp(64'd2500, 64'd2100);
		send_stamp(64'd4000, ALL_ONES);
		send_stamp(64'd5000, 64'h0000_0100_0000_0000);
		send_stamp(TIME_MAX, ALL_ONES);
		send_stamp(TIME_MIN, 64'd0);

		// undecoded indexes must not disturb tracking
		settle();
		write_reg(REG_UNUSED_LO, ALL_ONES);
		write_reg(REG_UNUSED_HI, 64'h1234_5678_9ABC_DEF0);
		cfg_we <= 1'b0;
		send_stamp(TIME_MIN + 64'd1, 64'd1);
		send_stamp(64'd0, 64'd0);

		// extreme base and slowest frame rate
		settle();
		write_reg(REG_REAL_BASE_TIME, TIME_MIN);
		write_reg(REG_USECS_PER_FRAME, {32'd0, UPF_MAX});
		cfg_we <= 1'b0;
		send_stamp(TIME_MAX, 64'd0);
		send_stamp(TIME_MAX, ALL_ONES);
		send_stamp(TIME_MIN, 64'd5);

		settle();
		write_reg(REG_USECS_PER_FRAME, 64'd1);
		cfg_we <= 1'b0;
		send_stamp(-64'd5, 64'd123);
		send_stamp(-64'd5, 64'd123);
		send_stamp(64'd10, 64'd1 << 40);
		send_stamp(64'd20, 64'd1 << 41);

		settle();
		write_reg(REG_REAL_BASE_TIME, TIME_MAX);
		write_reg(REG_USECS_PER_FRAME, {32'd0, UPF_RESET});
		cfg_we <= 1'b0;
		send_stamp(TIME_MAX, 64'd0);
		send_stamp(TIME_MIN, 64'd1000);

		// random phases, most under their own register setting
		for (int phase = 0; phase < 10; phase++) begin
			settle();
			case (phase)
				0: write_reg(REG_USECS_PER_FRAME, 64'd1);
				1: write_reg(REG_USECS_PER_FRAME, {32'd0, UPF_MAX});
				2: begin
					write_reg(REG_USECS_PER_FRAME, {32'd0, UPF_48K});
					write_reg(REG_REAL_BASE_TIME, TIME_MIN);
				end
				3: begin
					// receiver stalls long while requests keep coming
					write_reg(REG_REAL_BASE_TIME, TIME_MAX);
					gaps_on   = 1'b0;
					long_hold = 1'b1;
				end
				4: begin
					gaps_on = 1'b1;
					write_reg(REG_USECS_PER_FRAME, {32'd0, $urandom | 32'd1});
					write_reg(REG_REAL_BASE_TIME, rand64());
				end
				5: write_reg(REG_UNUSED_LO, rand64());
				6: write_reg(REG_USECS_PER_FRAME, {32'd0, UPF_48K});
				7: write_reg(REG_REAL_BASE_TIME, rand64());
				8: begin
					write_reg(REG_USECS_PER_FRAME, {32'd0, $urandom | 32'h8000_0000});
					write_reg(REG_REAL_BASE_TIME, 64'd0);
				end
				default: begin
					// closing stretch without idling on either side
					write_reg(REG_USECS_PER_FRAME, {32'd0, UPF_RESET});
					write_reg(REG_REAL_BASE_TIME, 64'd0);
					calm = 1'b1;
				end
			endcase
			cfg_we <= 1'b0;
			run_random_phase(61);
		end

		settle();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
